// ===== rtl/mp9p_pkg.sv =====
package mp9p_pkg;

	// Parser phases of the current message.
	typedef enum logic [3:0] {
		PH_SIZE     = 4'd0,
		PH_TYPE     = 4'd1,
		PH_TAG      = 4'd2,
		PH_FIELD    = 4'd3,
		PH_STRLEN   = 4'd4,
		PH_QTYPE    = 4'd5,
		PH_QVERS    = 4'd6,
		PH_QPATH    = 4'd7,
		PH_COUNT    = 4'd8,
		PH_DLEN     = 4'd9,
		PH_STRBYTES = 4'd10,
		PH_DBYTES   = 4'd11,
		PH_DONE     = 4'd12,
		PH_SKIP     = 4'd13
	} phase_t;

	// Operations of a message type's field program.
	typedef enum logic [2:0] {
		OP_END   = 3'd0,
		OP_FIX   = 3'd1,
		OP_STR   = 3'd2,
		OP_QID   = 3'd3,
		OP_WNAME = 3'd4,
		OP_WQID  = 3'd5,
		OP_DATA  = 3'd6
	} op_t;

	// Token kinds.
	localparam logic [4:0] K_SIZE    = 5'd0;
	localparam logic [4:0] K_TYPE    = 5'd1;
	localparam logic [4:0] K_TAG     = 5'd2;
	localparam logic [4:0] K_MSIZE   = 5'd3;
	localparam logic [4:0] K_AFID    = 5'd4;
	localparam logic [4:0] K_FID     = 5'd5;
	localparam logic [4:0] K_NEWFID  = 5'd6;
	localparam logic [4:0] K_OLDTAG  = 5'd7;
	localparam logic [4:0] K_NELEM   = 5'd8;
	localparam logic [4:0] K_STRLEN  = 5'd9;
	localparam logic [4:0] K_QTYPE   = 5'd10;
	localparam logic [4:0] K_QVERS   = 5'd11;
	localparam logic [4:0] K_QPATH   = 5'd12;
	localparam logic [4:0] K_IOUNIT  = 5'd13;
	localparam logic [4:0] K_PERM    = 5'd14;
	localparam logic [4:0] K_MODE    = 5'd15;
	localparam logic [4:0] K_OFFSET  = 5'd16;
	localparam logic [4:0] K_COUNT   = 5'd17;
	localparam logic [4:0] K_DLEN    = 5'd18;
	localparam logic [4:0] K_STATLEN = 5'd19;
	localparam logic [4:0] K_BYTE    = 5'd20;
	localparam logic [4:0] K_GOOD    = 5'd21;
	localparam logic [4:0] K_BAD     = 5'd22;

	// Verdict error codes.
	localparam logic [2:0] E_NONE      = 3'd0;
	localparam logic [2:0] E_SHORT     = 3'd1;
	localparam logic [2:0] E_SIZE      = 3'd2;
	localparam logic [2:0] E_TYPE      = 3'd3;
	localparam logic [2:0] E_TRUNC     = 3'd4;
	localparam logic [2:0] E_ELEMENTS  = 3'd5;
	localparam logic [2:0] E_TRAILING  = 3'd6;

	localparam logic [7:0]  TYPE_FIRST   = 8'd100;
	localparam logic [7:0]  TYPE_LAST    = 8'd127;
	localparam logic [7:0]  TYPE_INVALID = 8'd106;
	localparam logic [31:0] MIN_LENGTH   = 32'd7;

	typedef struct packed {
		op_t        op;
		logic [4:0] kind;
		logic [3:0] width;
	} step_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [63:0] value;
		logic [4:0]  slot;
		logic [2:0]  err;
		logic        fin;
	} token_t;

	// Whole parser state.
	typedef struct packed {
		logic [31:0] pos;
		logic        ovf;
		logic [31:0] declared;
		logic [7:0]  msg;
		phase_t      phase;
		logic [3:0]  left;
		logic [3:0]  width;
		logic [63:0] acc;
		logic [4:0]  kind;
		op_t         op;
		logic [2:0]  step;
		logic [31:0] plen;
		logic [4:0]  elem_left;
		logic [4:0]  elem_num;
		logic [2:0]  fault;
	} pstate_t;

	function automatic logic known_type(input logic [7:0] k);
		return k >= TYPE_FIRST && k <= TYPE_LAST && k != TYPE_INVALID;
	endfunction

	// Field program of each type, indexed by type minus 100 and step.
	function automatic step_t program_step(input logic [4:0] t, input logic [1:0] i);
		step_t s;
		s = '{OP_END, 5'd0, 4'd0};
		unique case ({t, i})
			{5'd0, 2'd0}, {5'd1, 2'd0}: s = '{OP_FIX, K_MSIZE, 4'd4};
			{5'd0, 2'd1}, {5'd1, 2'd1}: s = '{OP_STR, K_STRLEN, 4'd2};
			{5'd2, 2'd0}: s = '{OP_FIX, K_AFID, 4'd4};
			{5'd2, 2'd1}, {5'd2, 2'd2}: s = '{OP_STR, K_STRLEN, 4'd2};
			{5'd3, 2'd0}, {5'd5, 2'd0}: s = '{OP_QID, K_QTYPE, 4'd1};
			{5'd4, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd4, 2'd1}: s = '{OP_FIX, K_AFID, 4'd4};
			{5'd4, 2'd2}, {5'd4, 2'd3}: s = '{OP_STR, K_STRLEN, 4'd2};
			{5'd7, 2'd0}: s = '{OP_STR, K_STRLEN, 4'd2};
			{5'd8, 2'd0}: s = '{OP_FIX, K_OLDTAG, 4'd2};
			{5'd10, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd10, 2'd1}: s = '{OP_FIX, K_NEWFID, 4'd4};
			{5'd10, 2'd2}: s = '{OP_WNAME, K_NELEM, 4'd2};
			{5'd11, 2'd0}: s = '{OP_WQID, K_NELEM, 4'd2};
			{5'd12, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd12, 2'd1}: s = '{OP_FIX, K_MODE, 4'd1};
			{5'd13, 2'd0}, {5'd15, 2'd0}: s = '{OP_QID, K_QTYPE, 4'd1};
			{5'd13, 2'd1}, {5'd15, 2'd1}: s = '{OP_FIX, K_IOUNIT, 4'd4};
			{5'd14, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd14, 2'd1}: s = '{OP_STR, K_STRLEN, 4'd2};
			{5'd14, 2'd2}: s = '{OP_FIX, K_PERM, 4'd4};
			{5'd14, 2'd3}: s = '{OP_FIX, K_MODE, 4'd1};
			{5'd16, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd16, 2'd1}: s = '{OP_FIX, K_OFFSET, 4'd8};
			{5'd16, 2'd2}: s = '{OP_FIX, K_COUNT, 4'd4};
			{5'd17, 2'd0}: s = '{OP_DATA, K_DLEN, 4'd4};
			{5'd18, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd18, 2'd1}: s = '{OP_FIX, K_OFFSET, 4'd8};
			{5'd18, 2'd2}: s = '{OP_DATA, K_DLEN, 4'd4};
			{5'd19, 2'd0}: s = '{OP_FIX, K_COUNT, 4'd4};
			{5'd20, 2'd0}, {5'd22, 2'd0}, {5'd24, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd25, 2'd0}: s = '{OP_DATA, K_STATLEN, 4'd2};
			{5'd26, 2'd0}: s = '{OP_FIX, K_FID, 4'd4};
			{5'd26, 2'd1}: s = '{OP_DATA, K_STATLEN, 4'd2};
			default: s = '{OP_END, 5'd0, 4'd0};
		endcase
		return s;
	endfunction

	function automatic pstate_t begin_field(input pstate_t s, input phase_t ph,
			input logic [3:0] w, input logic [4:0] k);
		pstate_t r;
		r = s;
		r.phase = ph;
		r.width = w;
		r.left  = w;
		r.acc   = '0;
		r.kind  = k;
		return r;
	endfunction

	function automatic pstate_t next_op(input pstate_t s);
		pstate_t r;
		step_t   st;
		logic [7:0] t;
		r = s;
		t = s.msg - TYPE_FIRST;
		st = program_step(t[4:0], s.step[1:0]);
		if (s.step[2] || !known_type(s.msg)) begin
			r.phase = PH_DONE;
		end else begin
			r.step = s.step + 3'd1;
			r.op = st.op;
			unique case (st.op)
				OP_FIX:   r = begin_field(r, PH_FIELD, st.width, st.kind);
				OP_STR:   r = begin_field(r, PH_STRLEN, 4'd2, K_STRLEN);
				OP_QID:   r = begin_field(r, PH_QTYPE, 4'd1, K_QTYPE);
				OP_WNAME,
				OP_WQID:  r = begin_field(r, PH_COUNT, 4'd2, K_NELEM);
				OP_DATA:  r = begin_field(r, PH_DLEN, st.width, st.kind);
				default:  r.phase = PH_DONE;
			endcase
		end
		return r;
	endfunction

	function automatic pstate_t string_done(input pstate_t s);
		pstate_t r;
		r = s;
		r.elem_num = s.elem_num + 5'd1;
		if (s.op == OP_WNAME && s.elem_left > 5'd1) begin
			r.elem_left = s.elem_left - 5'd1;
			r = begin_field(r, PH_STRLEN, 4'd2, K_STRLEN);
		end else begin
			r.elem_left = '0;
			r = next_op(r);
		end
		return r;
	endfunction

	function automatic pstate_t qid_done(input pstate_t s);
		pstate_t r;
		r = s;
		if (s.op == OP_WQID) begin
			r.elem_num = s.elem_num + 5'd1;
			if (s.elem_left > 5'd1) begin
				r.elem_left = s.elem_left - 5'd1;
				r = begin_field(r, PH_QTYPE, 4'd1, K_QTYPE);
			end else begin
				r.elem_left = '0;
				r = next_op(r);
			end
		end else begin
			r = next_op(r);
		end
		return r;
	endfunction

	function automatic pstate_t latch_fault(input pstate_t s, input logic [2:0] code);
		pstate_t r;
		r = s;
		if (s.fault == E_NONE) begin
			r.fault = code;
		end
		r.phase = PH_SKIP;
		return r;
	endfunction

	// State at reset and at the start of each message.
	function automatic pstate_t fresh_state();
		pstate_t r;
		r = '0;
		r.phase = PH_SIZE;
		r.op = OP_END;
		r.width = 4'd4;
		r.left = 4'd4;
		r.kind = K_SIZE;
		return r;
	endfunction

endpackage

// ===== rtl/message_parser_9p2000.sv =====
// 9P2000 message parser.
// Slave channel s_*: one message byte per request in s_tdata[7:0], with
// s_tlast on the final byte of each message.
// Master channel m_*: one token per request. A verdict token (good or bad,
// with its error code) carries m_tlast and closes the message; after a bad
// verdict the consumer drops that message's earlier tokens.
// Throughput: one byte per cycle while s_tready is high. Each byte is
// parsed in the cycle it is accepted, and its token is written into the queue.
// A final byte that also closes a field yields two tokens, taken one per
// cycle while m_tready is high. Tokens wait in a four-entry queue; s_tready
// is high while the queue has at least two free entries, so a stalled
// receiver holds input back once three tokens are waiting; nothing is lost.
// Reset clears the parser and the queue; the first byte after reset starts
// a message with its size field.
module message_parser_9p2000 #(
	parameter int MAX_WALK_ELEMENTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [4:0] token_kind, [68:5] token_value,
	                               // [73:69] slot_index, [76:74] error_code
	output logic        m_tlast    // final_token
);

	logic             take;
	logic             a_vld;
	logic             b_vld;
	mp9p_pkg::token_t tok_a;
	mp9p_pkg::token_t tok_b;
	mp9p_pkg::token_t head;

	assign take = s_tvalid && s_tready;

	mp9p_parse #(
		.MAX_WALK_ELEMENTS(MAX_WALK_ELEMENTS)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (s_tdata),
		.end_of_message (s_tlast),
		.tok_a_vld      (a_vld),
		.tok_a          (tok_a),
		.tok_b_vld      (b_vld),
		.tok_b          (tok_b)
	);

	mp9p_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push_a  (take && a_vld),
		.din_a   (tok_a),
		.push_b  (take && b_vld),
		.din_b   (tok_b),
		.room    (s_tready),
		.out_vld (m_tvalid),
		.dout    (head),
		.pop     (m_tready)
	);

	// Pack the head token onto the master bus.
	assign m_tdata = {3'b000, head.err, head.slot, head.value, head.kind};
	assign m_tlast = head.fin;

endmodule

// ===== rtl/mp9p_parse.sv =====
module mp9p_parse #(
	parameter int MAX_WALK_ELEMENTS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [7:0]      data_byte,
	input  logic            end_of_message,
	output logic            tok_a_vld,
	output mp9p_pkg::token_t tok_a,
	output logic            tok_b_vld,
	output mp9p_pkg::token_t tok_b
);

	mp9p_pkg::pstate_t st_q;
	mp9p_pkg::pstate_t s;
	logic [3:0]  left_n;
	logic [2:0]  bpos;
	logic [63:0] v;
	logic        str;
	logic [2:0]  code;

	// Advance the parser by one byte and form up to two tokens.
	always_comb begin
		s = st_q;
		tok_a_vld = 1'b0;
		tok_a = '0;
		tok_b_vld = 1'b0;
		tok_b = '0;
		left_n = '0;
		bpos = '0;
		v = '0;
		str = 1'b0;
		code = mp9p_pkg::E_NONE;

		if (s.pos == 32'hFFFF_FFFF) begin
			s.ovf = 1'b1;
		end else begin
			s.pos = s.pos + 32'd1;
		end

		if (s.phase <= mp9p_pkg::PH_DLEN) begin
			left_n = (s.left == 4'd0 || s.left > s.width) ? s.width : s.left;
			bpos = 3'(s.width - left_n);
			s.acc = s.acc | (64'(data_byte) << {bpos, 3'b000});
			s.left = left_n - 4'd1;
			if (s.left == 4'd0) begin
				v = s.acc;
				tok_a_vld = 1'b1;
				tok_a.kind = s.kind;
				tok_a.value = v;
				if (s.phase == mp9p_pkg::PH_STRLEN || s.phase == mp9p_pkg::PH_QTYPE ||
						s.phase == mp9p_pkg::PH_QVERS || s.phase == mp9p_pkg::PH_QPATH) begin
					tok_a.slot = s.elem_num;
				end
				unique case (s.phase)
					mp9p_pkg::PH_SIZE: begin
						s.declared = v[31:0];
						s = mp9p_pkg::begin_field(s, mp9p_pkg::PH_TYPE, 4'd1, mp9p_pkg::K_TYPE);
					end
					mp9p_pkg::PH_TYPE: begin
						s.msg = v[7:0];
						s = mp9p_pkg::begin_field(s, mp9p_pkg::PH_TAG, 4'd2, mp9p_pkg::K_TAG);
					end
					mp9p_pkg::PH_TAG: begin
						if (mp9p_pkg::known_type(s.msg)) begin
							s = mp9p_pkg::next_op(s);
						end else begin
							s = mp9p_pkg::latch_fault(s, mp9p_pkg::E_TYPE);
						end
					end
					mp9p_pkg::PH_FIELD: s = mp9p_pkg::next_op(s);
					mp9p_pkg::PH_STRLEN: begin
						s.plen = v[31:0];
						if (v == 64'd0) begin
							s = mp9p_pkg::string_done(s);
						end else begin
							s.phase = mp9p_pkg::PH_STRBYTES;
						end
					end
					mp9p_pkg::PH_QTYPE:
						s = mp9p_pkg::begin_field(s, mp9p_pkg::PH_QVERS, 4'd4, mp9p_pkg::K_QVERS);
					mp9p_pkg::PH_QVERS:
						s = mp9p_pkg::begin_field(s, mp9p_pkg::PH_QPATH, 4'd8, mp9p_pkg::K_QPATH);
					mp9p_pkg::PH_QPATH: s = mp9p_pkg::qid_done(s);
					mp9p_pkg::PH_COUNT: begin
						if (v > 64'(MAX_WALK_ELEMENTS)) begin
							s = mp9p_pkg::latch_fault(s, mp9p_pkg::E_ELEMENTS);
						end else begin
							s.elem_left = v[4:0];
							s.elem_num = '0;
							if (v == 64'd0) begin
								s = mp9p_pkg::next_op(s);
							end else if (s.op == mp9p_pkg::OP_WNAME) begin
								s = mp9p_pkg::begin_field(s, mp9p_pkg::PH_STRLEN, 4'd2,
									mp9p_pkg::K_STRLEN);
							end else begin
								s = mp9p_pkg::begin_field(s, mp9p_pkg::PH_QTYPE, 4'd1,
									mp9p_pkg::K_QTYPE);
							end
						end
					end
					mp9p_pkg::PH_DLEN: begin
						s.plen = v[31:0];
						if (v == 64'd0) begin
							s = mp9p_pkg::next_op(s);
						end else begin
							s.phase = mp9p_pkg::PH_DBYTES;
						end
					end
					default: s = s;
				endcase
			end
		end else if (s.phase == mp9p_pkg::PH_STRBYTES || s.phase == mp9p_pkg::PH_DBYTES) begin
			str = (s.phase == mp9p_pkg::PH_STRBYTES);
			tok_a_vld = 1'b1;
			tok_a.kind = mp9p_pkg::K_BYTE;
			tok_a.value = 64'(data_byte);
			tok_a.slot = str ? s.elem_num : 5'd0;
			if (s.plen != 32'd0) begin
				s.plen = s.plen - 32'd1;
			end
			if (s.plen == 32'd0) begin
				s = str ? mp9p_pkg::string_done(s) : mp9p_pkg::next_op(s);
			end
		end else if (s.phase == mp9p_pkg::PH_DONE) begin
			s = mp9p_pkg::latch_fault(s, mp9p_pkg::E_TRAILING);
		end

		// Verdict on the final byte, first failing check wins.
		if (end_of_message) begin
			priority if (!s.ovf && s.pos < mp9p_pkg::MIN_LENGTH) begin
				code = mp9p_pkg::E_SHORT;
			end else if (s.ovf || s.declared != s.pos) begin
				code = mp9p_pkg::E_SIZE;
			end else if (s.fault != mp9p_pkg::E_NONE) begin
				code = s.fault;
			end else if (s.phase != mp9p_pkg::PH_DONE) begin
				code = mp9p_pkg::E_TRUNC;
			end else begin
				code = mp9p_pkg::E_NONE;
			end
			tok_b_vld = 1'b1;
			tok_b.kind = (code == mp9p_pkg::E_NONE) ? mp9p_pkg::K_GOOD : mp9p_pkg::K_BAD;
			tok_b.err = code;
			tok_b.fin = 1'b1;
			s = mp9p_pkg::fresh_state();
		end
	end

	// Parser state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= mp9p_pkg::fresh_state();
		end else if (take) begin
			st_q <= s;
		end
	end

endmodule

// ===== rtl/mp9p_queue.sv =====
module mp9p_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_a,
	input  mp9p_pkg::token_t din_a,
	input  logic             push_b,
	input  mp9p_pkg::token_t din_b,
	output logic             room,
	output logic             out_vld,
	output mp9p_pkg::token_t dout,
	input  logic             pop
);

	mp9p_pkg::token_t mem_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic [1:0] wr_b;
	logic [2:0] n_push;
	logic       do_pop;

	assign out_vld = (cnt_q != 3'd0);
	assign dout    = mem_q[rd_q];
	assign room    = (cnt_q <= 3'd2);
	assign do_pop  = pop && out_vld;
	assign wr_b    = push_a ? wr_q + 2'd1 : wr_q;
	assign n_push  = 3'(push_a) + 3'(push_b);

	// Token storage, up to two writes a cycle.
	always_ff @(posedge clk) begin
		if (push_a) begin
			mem_q[wr_q] <= din_a;
		end
		if (push_b) begin
			mem_q[wr_b] <= din_b;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_push[1:0];
			if (do_pop) begin
				rd_q <= rd_q + 2'd1;
			end
			cnt_q <= cnt_q + n_push - 3'(do_pop);
		end
	end

endmodule
